// File: hw/rtl/rational_arith_reduce_assert.svh
// assertion macros shared by the rational_arith_reduce rtl
// no dependencies; included by the top module rational_arith_reduce, which checks its own logic
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// same-cycle implication
`define RAR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rar_pkg.sv
// shared types and constants of the rational_arith_reduce block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_WIDTH         = 34;
   localparam int CSR_INDEX_WIDTH   = 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BASE_NUM = 1'b0,
      CSR_BASE_DEN = 1'b1
   } csr_index_type;

   // status of an iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/rar_chan_if.sv
// valid/ready channels of the rational_arith_reduce block: request and response
// depends on rar_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rar_req_if #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
);
   logic                            valid;
   logic                            ready;
   logic [1:0]                      opcode;
   logic signed [OPERAND_WIDTH-1:0] operand_numerator;
   logic signed [OPERAND_WIDTH-1:0] operand_denominator;

   modport source (
      output valid, opcode, operand_numerator, operand_denominator,
      input  ready
   );
   modport sink (
      input  valid, opcode, operand_numerator, operand_denominator,
      output ready
   );
endinterface

interface rar_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rar_pkg::RES_WIDTH-1:0] result_numerator;
   logic signed [rar_pkg::RES_WIDTH-1:0] result_denominator;
   logic                                error_flag;

   modport source (
      output valid, result_numerator, result_denominator, error_flag,
      input  ready
   );
   modport sink (
      input  valid, result_numerator, result_denominator, error_flag,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/rar_mul.sv
// shared signed multiplier with registered product
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rar_mul #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic signed [OPERAND_WIDTH-1:0]   mul_x,
   input  wire logic signed [OPERAND_WIDTH-1:0]   mul_y,
   output      logic signed [2*OPERAND_WIDTH-1:0] product
);

   logic signed [2*OPERAND_WIDTH-1:0] product_ff;
   logic signed [2*OPERAND_WIDTH-1:0] product_in;

   assign product_in = (2*OPERAND_WIDTH)'(mul_x) * (2*OPERAND_WIDTH)'(mul_y);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rar_gcd.sv
// binary gcd of two nonzero magnitudes, one shift or subtract step per cycle
// depends on rar_pkg; returns the odd part of the gcd and both inputs with
// the common power of two removed
`timescale 1ns / 1ps
`default_nettype none

module rar_gcd #(
   parameter int MAG_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MAG_WIDTH-1:0] u_start,
   input  wire logic [MAG_WIDTH-1:0] v_start,
   output      rar_pkg::unit_stat_type stat,
   output      logic [MAG_WIDTH-1:0] gcd_odd,
   output      logic [MAG_WIDTH-1:0] u_shifted,
   output      logic [MAG_WIDTH-1:0] v_shifted
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SHIFT,
      PH_REDUCE
   } phase_type;

   phase_type            phase_ff;
   logic                 done_ff;
   logic [MAG_WIDTH-1:0] u_ff;
   logic [MAG_WIDTH-1:0] v_ff;
   logic [MAG_WIDTH-1:0] us_ff;
   logic [MAG_WIDTH-1:0] vs_ff;
   logic [MAG_WIDTH-1:0] u_minus_v;
   logic [MAG_WIDTH-1:0] v_minus_u;
   logic                 u_gt_v;

   assign u_minus_v = u_ff - v_ff;
   assign v_minus_u = v_ff - u_ff;
   assign u_gt_v    = u_ff > v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  u_ff     <= u_start;
                  v_ff     <= v_start;
                  phase_ff <= PH_SHIFT;
               end
            end
            PH_SHIFT: begin
               // strip the common factor of two from both values
               if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
               end else begin
                  us_ff    <= u_ff;
                  vs_ff    <= v_ff;
                  phase_ff <= PH_REDUCE;
               end
            end
            PH_REDUCE: begin
               priority if (u_ff == v_ff) begin
                  done_ff  <= 1'b1;
                  phase_ff <= PH_IDLE;
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_gt_v) begin
                  u_ff <= u_minus_v >> 1;
               end else begin
                  v_ff <= v_minus_u >> 1;
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign stat.busy = phase_ff != PH_IDLE;
   assign stat.done = done_ff;
   assign gcd_odd   = u_ff;
   assign u_shifted = us_ff;
   assign v_shifted = vs_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rar_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on rar_pkg
`timescale 1ns / 1ps
`default_nettype none

module rar_div #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output      rar_pkg::unit_stat_type stat,
   output      logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] dsr_ff;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] rem_in;
   logic [WIDTH-1:0] quo_in;

   assign rem_sh = {rem_ff, quo_ff[WIDTH-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign rem_in = diff[WIDTH] ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
   assign quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= CW'(WIDTH);
               rem_ff  <= '0;
               quo_ff  <= dividend;
               dsr_ff  <= divisor;
            end
         end else begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rational_arith_reduce.sv
// top level of the fraction arithmetic block: sequencer, registers, units
// depends on rar_pkg, rar_chan_if, rar_mul, rar_gcd, rar_div and the assert header
`timescale 1ns / 1ps
`default_nettype none

// Fraction unit: combines the stored fraction a/b (csr registers 0 and 1, a zero
// write to the denominator is dropped) with the operand c/d by add, subtract,
// multiply or divide, and returns numerator and denominator divided by the gcd
// of their magnitudes, each keeping its own sign, as 34-bit values. A zero
// result gives 0/1; a zero operand denominator, or a zero divisor numerator,
// gives 0/0 with error_flag set. One item is worked on at a time and req is not
// ready meanwhile. An item goes through the three products on the shared
// multiplier and the sign handling, the start of the gcd, the binary gcd loop
// at one step per cycle, two restoring divisions, the load of the response and
// the return to idle to take the next request. Error cases go straight to the
// response load; zero cases go there after the sign handling. The result sits
// in an output register, so the next request is taken while a response still
// waits for its transfer.
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [rar_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [OPERAND_WIDTH-1:0]            csr_wdata,
   rar_req_if.sink                                  req_chan,
   rar_rsp_if.source                                rsp_chan
);

   `include "rational_arith_reduce_assert.svh"

   localparam int W      = OPERAND_WIDTH;
   localparam int PW     = 2 * W;
   localparam int NW     = 2 * W + 1;
   localparam int MW     = 2 * W;
   localparam int RW     = rar_pkg::RES_WIDTH;
   localparam int EW     = (MW > RW) ? MW : RW;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_MAG,
      ST_GCD,
      ST_DIVN,
      ST_DIVM,
      ST_FINISH
   } state_type;

   state_type               state_ff;
   logic signed [W-1:0]     base_num_ff;
   logic signed [W-1:0]     base_den_ff;
   rar_pkg::opcode_type     op_ff;
   logic signed [W-1:0]     c_ff;
   logic signed [W-1:0]     d_ff;
   logic signed [PW-1:0]    t0_ff;
   logic signed [PW-1:0]    t1_ff;
   logic signed [NW-1:0]    n_ff;
   logic signed [PW-1:0]    m_ff;
   logic [MW-1:0]           n_mag_ff;
   logic [MW-1:0]           m_mag_ff;
   logic                    n_neg_ff;
   logic                    m_neg_ff;
   logic                    err_ff;
   logic                    zero_ff;
   logic [MW-1:0]           qn_ff;
   logic [MW-1:0]           qm_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [RW-1:0]    rsp_num_ff;
   logic signed [RW-1:0]    rsp_den_ff;
   logic                    rsp_err_ff;

   logic signed [W-1:0]     mul_x;
   logic signed [W-1:0]     mul_y;
   logic signed [PW-1:0]    product;
   logic signed [NW-1:0]    t0_x;
   logic signed [NW-1:0]    t1_x;
   logic signed [NW-1:0]    n_in;
   logic signed [NW-1:0]    n_neg_val;
   logic signed [PW-1:0]    m_neg_val;
   logic                    req_fire;
   logic                    req_err;
   logic                    out_free;

   logic                    gcd_start;
   rar_pkg::unit_stat_type  gcd_stat;
   logic [MW-1:0]           gcd_g;
   logic [MW-1:0]           gcd_nq;
   logic [MW-1:0]           gcd_mq;

   logic                    div_start;
   logic [MW-1:0]           div_dividend;
   rar_pkg::unit_stat_type  div_stat;
   logic [MW-1:0]           div_quo;

   logic [EW-1:0]           qn_ext;
   logic [EW-1:0]           qm_ext;
   logic [EW-1:0]           num_signed;
   logic [EW-1:0]           den_signed;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_num_ff <= '0;
         base_den_ff <= W'(1);
      end else if (csr_we) begin
         unique case (rar_pkg::csr_index_type'(csr_index))
            rar_pkg::CSR_BASE_NUM: base_num_ff <= csr_wdata;
            rar_pkg::CSR_BASE_DEN: begin
               if (csr_wdata != '0) begin
                  base_den_ff <= csr_wdata;
               end
            end
            default: ;
         endcase
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (state_ff)
         ST_MUL0: begin
            mul_x = base_num_ff;
            mul_y = (op_ff == rar_pkg::OP_MUL) ? c_ff : d_ff;
         end
         ST_MUL1: begin
            mul_x = c_ff;
            mul_y = base_den_ff;
         end
         ST_MUL2: begin
            mul_x = base_den_ff;
            mul_y = (op_ff == rar_pkg::OP_DIV) ? c_ff : d_ff;
         end
         default: ;
      endcase
   end

   rar_mul #(
      .OPERAND_WIDTH (W)
   ) u_mul (
      .clock   (clock),
      .mul_x   (mul_x),
      .mul_y   (mul_y),
      .product (product)
   );

   assign t0_x = NW'(t0_ff);
   assign t1_x = NW'(t1_ff);

   always_comb begin
      unique case (op_ff)
         rar_pkg::OP_ADD: n_in = t0_x + t1_x;
         rar_pkg::OP_SUB: n_in = t0_x - t1_x;
         default:         n_in = t0_x;
      endcase
   end

   assign n_neg_val = -n_ff;
   assign m_neg_val = -m_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_err  = (req_chan.operand_denominator == '0) ||
                     ((rar_pkg::opcode_type'(req_chan.opcode) == rar_pkg::OP_DIV) &&
                      (req_chan.operand_numerator == '0));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // gcd starts in the first gcd cycle, once the magnitudes are registered
   assign gcd_start = (state_ff == ST_GCD) && !gcd_stat.busy && !gcd_stat.done;

   rar_gcd #(
      .MAG_WIDTH (MW)
   ) u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start),
      .u_start   (n_mag_ff),
      .v_start   (m_mag_ff),
      .stat      (gcd_stat),
      .gcd_odd   (gcd_g),
      .u_shifted (gcd_nq),
      .v_shifted (gcd_mq)
   );

   // numerator division starts when the gcd is done, denominator when the numerator one is done
   assign div_start    = ((state_ff == ST_GCD) && gcd_stat.done) ||
                         ((state_ff == ST_DIVN) && div_stat.done);
   assign div_dividend = (state_ff == ST_GCD) ? gcd_nq : gcd_mq;

   rar_div #(
      .WIDTH (MW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_g),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign qn_ext     = EW'(qn_ff);
   assign qm_ext     = EW'(qm_ff);
   assign num_signed = n_neg_ff ? -qn_ext : qn_ext;
   assign den_signed = m_neg_ff ? -qm_ext : qm_ext;

   assign rsp_valid_in = ((state_ff == ST_FINISH) && out_free) ||
                         (rsp_valid_ff && !rsp_chan.ready);

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff   <= rar_pkg::opcode_type'(req_chan.opcode);
                  c_ff    <= req_chan.operand_numerator;
                  d_ff    <= req_chan.operand_denominator;
                  err_ff  <= req_err;
                  zero_ff <= 1'b0;
                  state_ff <= req_err ? ST_FINISH : ST_MUL0;
               end
            end
            ST_MUL0: state_ff <= ST_MUL1;
            ST_MUL1: begin
               t0_ff    <= product;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               t1_ff    <= product;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               m_ff     <= product;
               n_ff     <= n_in;
               state_ff <= ST_MAG;
            end
            ST_MAG: begin
               n_neg_ff <= n_ff[NW-1];
               m_neg_ff <= m_ff[PW-1];
               n_mag_ff <= n_ff[NW-1] ? n_neg_val[MW-1:0] : n_ff[MW-1:0];
               m_mag_ff <= m_ff[PW-1] ? m_neg_val : m_ff;
               if (n_ff == '0) begin
                  zero_ff  <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_GCD;
               end
            end
            ST_GCD: begin
               if (gcd_stat.done) begin
                  state_ff <= ST_DIVN;
               end
            end
            ST_DIVN: begin
               if (div_stat.done) begin
                  qn_ff    <= div_quo;
                  state_ff <= ST_DIVM;
               end
            end
            ST_DIVM: begin
               if (div_stat.done) begin
                  qm_ff    <= div_quo;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  priority if (err_ff) begin
                     rsp_num_ff <= '0;
                     rsp_den_ff <= '0;
                     rsp_err_ff <= 1'b1;
                  end else if (zero_ff) begin
                     rsp_num_ff <= '0;
                     rsp_den_ff <= RW'(1);
                     rsp_err_ff <= 1'b0;
                  end else begin
                     rsp_num_ff <= num_signed[RW-1:0];
                     rsp_den_ff <= den_signed[RW-1:0];
                     rsp_err_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready              = state_ff == ST_IDLE;
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.result_numerator   = rsp_num_ff;
   assign rsp_chan.result_denominator = rsp_den_ff;
   assign rsp_chan.error_flag         = rsp_err_ff;

   `RAR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_chan.ready,
      "request taken while an item is in flight")
   `RAR_ASSERT_IMPL(a_gcd_nonzero, clock, reset, gcd_stat.done, gcd_g != '0,
      "gcd finished with a zero divisor")
   `RAR_ASSERT_IMPL(a_div_start_idle, clock, reset, div_start, !div_stat.busy,
      "divider started while busy")
   `RAR_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid_ff && rsp_err_ff,
      (rsp_num_ff == '0) && (rsp_den_ff == '0), "error response with nonzero values")

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking testbench of rational_arith_reduce: directed and random fraction ops
// depends on rar_pkg, rar_chan_if and the rational_arith_reduce rtl
`timescale 1ns / 1ps

module testbench;

   localparam int OPW = 16;
   localparam logic signed [OPW-1:0] OP_MIN = {1'b1, {(OPW-1){1'b0}}};
   localparam logic signed [OPW-1:0] OP_MAX = {1'b0, {(OPW-1){1'b1}}};

   typedef struct packed {
      logic signed [rar_pkg::RES_WIDTH-1:0] num;
      logic signed [rar_pkg::RES_WIDTH-1:0] den;
      logic                                 err;
   } reduced_frac_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   rar_pkg::csr_index_type csr_index = rar_pkg::CSR_BASE_NUM;
   logic [OPW-1:0] csr_wdata = '0;

   rar_req_if #(.OPERAND_WIDTH(OPW)) req_chan ();
   rar_rsp_if rsp_chan ();

   rational_arith_reduce #(.OPERAND_WIDTH(OPW)) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #5 clock = ~clock;

   // stored fraction as the block should hold it
   longint base_num = 0;
   longint base_den = 1;
   reduced_frac_type awaited_fractions[$];
   int errors = 0;
   int req_idle_pct = 19;
   int rsp_idle_pct = 76;
   int rsp_stall_left = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = rar_pkg::OP_ADD;
      req_chan.operand_numerator = '0;
      req_chan.operand_denominator = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic reduced_frac_type reduce_fraction(rar_pkg::opcode_type op,
                                                        logic signed [OPW-1:0] c_in,
                                                        logic signed [OPW-1:0] d_in);
      reduced_frac_type r;
      longint c, d, n, m;
      longint unsigned nm, mm, x, y, t;
      r = '0;
      c = c_in;
      d = d_in;
      if (d == 0 || (op == rar_pkg::OP_DIV && c == 0)) begin
         r.err = 1'b1;
         return r;
      end
      case (op)
         rar_pkg::OP_ADD: begin n = base_num * d + c * base_den; m = base_den * d; end
         rar_pkg::OP_SUB: begin n = base_num * d - c * base_den; m = base_den * d; end
         rar_pkg::OP_MUL: begin n = base_num * c; m = base_den * d; end
         default: begin n = base_num * d; m = base_den * c; end
      endcase
      if (n == 0) begin
         r.den = rar_pkg::RES_WIDTH'(1);
         return r;
      end
      nm = (n < 0) ? -n : n;
      mm = (m < 0) ? -m : m;
      x = nm;
      y = mm;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      // each quotient keeps its own sign, wrapped to the result width
      r.num = rar_pkg::RES_WIDTH'((n < 0) ? -longint'(nm / x) : longint'(nm / x));
      r.den = rar_pkg::RES_WIDTH'((m < 0) ? -longint'(mm / x) : longint'(mm / x));
      return r;
   endfunction

   function automatic logic [OPW-1:0] pick_value();
      int sel;
      sel = $urandom_range(15);
      if (sel == 0) begin
         case ($urandom_range(4))
            0: return OPW'(OP_MIN);
            1: return OPW'(-1);
            2: return '0;
            3: return OPW'(1);
            default: return OPW'(OP_MAX);
         endcase
      end else if (sel <= 5) begin
         return OPW'(int'($urandom_range(40)) - 20);
      end
      return OPW'($urandom);
   endfunction

   // receiver side: random stalls with the occasional long one
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct) begin
         rsp_chan.ready <= 1'b0;
         if ($urandom_range(63) == 0)
            rsp_stall_left = $urandom_range(250, 10);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_result
      reduced_frac_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_fractions.size() == 0) begin
            $display("%0t unexpected result transfer: num %0d den %0d err %0b", $time,
                     rsp_chan.result_numerator, rsp_chan.result_denominator,
                     rsp_chan.error_flag);
            errors++;
         end else begin
            want = awaited_fractions.pop_front();
            if (rsp_chan.result_numerator !== want.num) begin
               $display("%0t result_numerator mismatch: expected %0d, actual %0d", $time,
                        $signed(want.num), rsp_chan.result_numerator);
               errors++;
            end
            if (rsp_chan.result_denominator !== want.den) begin
               $display("%0t result_denominator mismatch: expected %0d, actual %0d", $time,
                        $signed(want.den), rsp_chan.result_denominator);
               errors++;
            end
            if (rsp_chan.error_flag !== want.err) begin
               $display("%0t error_flag mismatch: expected %0b, actual %0b", $time,
                        want.err, rsp_chan.error_flag);
               errors++;
            end
         end
      end
   end

   task automatic issue_op(rar_pkg::opcode_type op, logic signed [OPW-1:0] c,
                           logic signed [OPW-1:0] d);
      int gap;
      gap = 0;
      if (req_idle_pct > 0) begin
         if ($urandom_range(31) == 0)
            gap = $urandom_range(200, 1);
         else
            while (gap < 20 && $urandom_range(99) < req_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.operand_numerator <= c;
      req_chan.operand_denominator <= d;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      awaited_fractions.push_back(reduce_fraction(op, c, d));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      int cycles;
      cycles = 0;
      req_chan.valid <= 1'b0;
      while (awaited_fractions.size() != 0 && cycles < 50000) begin
         @(negedge clock);
         cycles++;
      end
   endtask

   // registers are only written once every result is back
   task automatic load_base(logic [OPW-1:0] num, logic [OPW-1:0] den);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= rar_pkg::CSR_BASE_NUM;
      csr_wdata <= num;
      @(negedge clock);
      base_num = $signed(num);
      csr_index <= rar_pkg::CSR_BASE_DEN;
      csr_wdata <= den;
      @(negedge clock);
      if (den != 0)
         base_den = $signed(den);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_base();
      issue_op(rar_pkg::OP_ADD, 3, 4);
      issue_op(rar_pkg::OP_MUL, 5, 7);
      issue_op(rar_pkg::OP_DIV, 0, 5);
      issue_op(rar_pkg::OP_SUB, -6, -8);
   endtask

   task automatic test_extreme_base();
      load_base(OPW'(OP_MIN), OPW'(OP_MAX));
      issue_op(rar_pkg::OP_ADD, OP_MAX, OP_MIN);
      issue_op(rar_pkg::OP_SUB, OP_MIN, OP_MIN);
      issue_op(rar_pkg::OP_MUL, OP_MIN, -1);
      issue_op(rar_pkg::OP_DIV, OP_MAX, OP_MIN);
      // zero operand denominator on every op, then divide by zero
      issue_op(rar_pkg::OP_ADD, 7, 0);
      issue_op(rar_pkg::OP_SUB, 1, 0);
      issue_op(rar_pkg::OP_MUL, OP_MIN, 0);
      issue_op(rar_pkg::OP_DIV, 1, 0);
      issue_op(rar_pkg::OP_DIV, 0, 1);
      load_base(OPW'(OP_MAX), OPW'(OP_MIN));
      issue_op(rar_pkg::OP_ADD, OP_MAX, OP_MIN);
      issue_op(rar_pkg::OP_MUL, OP_MAX, OP_MAX);
      issue_op(rar_pkg::OP_DIV, OP_MIN, 1);
   endtask

   task automatic test_sign_and_zero();
      load_base(6, OPW'(-4));
      // zero write to the denominator is dropped, -4 stays
      load_base(6, 0);
      issue_op(rar_pkg::OP_SUB, 3, -2);
      issue_op(rar_pkg::OP_ADD, 1, -1);
      issue_op(rar_pkg::OP_MUL, -2, 3);
      issue_op(rar_pkg::OP_DIV, -9, -6);
      issue_op(rar_pkg::OP_MUL, 0, -5);
   endtask

   task automatic test_random_ops(int count);
      int until_cfg;
      logic [OPW-1:0] num, den;
      until_cfg = $urandom_range(60, 20);
      for (int i = 0; i < count; i++) begin
         if (until_cfg == 0) begin
            num = pick_value();
            den = ($urandom_range(15) == 0) ? '0 : pick_value();
            load_base(num, den);
            until_cfg = $urandom_range(60, 20);
         end
         until_cfg--;
         issue_op(rar_pkg::opcode_type'($urandom_range(3)), pick_value(), pick_value());
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_base();
      test_extreme_base();
      test_sign_and_zero();
      test_random_ops(280);
      req_idle_pct = 76;
      rsp_idle_pct = 19;
      test_random_ops(280);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_ops(280);
      wait_idle();
      repeat (200) @(negedge clock);
      if (awaited_fractions.size() != 0) begin
         $display("%0t %0d results never arrived", $time, awaited_fractions.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASS rational_arith_reduce");
      end else begin
         $display("FAIL rational_arith_reduce");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("FAIL rational_arith_reduce");
      $finish;
   end

endmodule
